// ===== hdl/cfbs_pkg.sv =====
// Package for the chained free-block stack: sizes, command codes and result kinds.
// No dependencies; used by the top level and its testbench.
package cfbs_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int BLOCK_BITS  = 32;

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  localparam int CMD_W  = 2;
  localparam int WORD_W = 32;
  localparam int IDX_W  = 6;

  localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REFILL = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RSVD   = 2'd3;

  typedef enum logic [2:0] {
    KIND_ALLOC  = 3'd0,
    KIND_EMPTY  = 3'd1,
    KIND_FREED  = 3'd2,
    KIND_SPILL  = 3'd3,
    KIND_ACCEPT = 3'd4,
    KIND_BUSY   = 3'd5,
    KIND_CLAMP  = 3'd6
  } kind_t;

endpackage

// ===== hdl/chained_free_block_stack.sv =====
// Top level of the chained free-block stack: command sequencer around the stack RAM.
// Depends on cfbs_pkg and cfbs_ram.

// A command is taken when start is high and busy is low. Refill words, rejected
// commands, empty allocates and frees onto a non-full stack answer with one result
// strobe in the cycle after the transfer, and busy stays low: one item per cycle.
// An allocate reads the stack RAM once and answers from S_POP once the registered
// read data is back, busy high in between. A free onto a full stack streams the
// count word, then STACK_DEPTH entries read one per cycle from the RAM port, then
// the freed result. Results are valid on out_valid for one cycle each; the
// receiver cannot stall them, and out_last marks the final result of a command.
module chained_free_block_stack (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [cfbs_pkg::CMD_W-1:0]  in_cmd,
  input  logic [cfbs_pkg::WORD_W-1:0] in_block_number,
  input  logic [cfbs_pkg::WORD_W-1:0] in_refill_word,
  output logic                        out_valid,
  output logic [2:0]                  out_kind,
  output logic [cfbs_pkg::WORD_W-1:0] out_result_block,
  output logic                        out_refill_request,
  output logic [cfbs_pkg::IDX_W-1:0]  out_word_index,
  output logic [cfbs_pkg::WORD_W-1:0] out_word_value,
  output logic [cfbs_pkg::IDX_W-1:0]  out_entries_now,
  output logic                        out_last
);
  import cfbs_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SPILL,
    S_FIN
  } state_t;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  refilling_r, refilling_nxt;
  logic                  seen_r, seen_nxt;
  logic [CNT_W-1:0]      expect_r, expect_nxt;
  logic [CNT_W-1:0]      k_r, k_nxt;
  logic [BLOCK_BITS-1:0] blk_r, blk_nxt;

  logic                  ov_r, ov_nxt;
  kind_t                 kind_r, kind_nxt;
  logic [WORD_W-1:0]     rblk_r, rblk_nxt;
  logic                  req_r, req_nxt;
  logic [IDX_W-1:0]      widx_r, widx_nxt;
  logic [WORD_W-1:0]     wval_r, wval_nxt;
  logic [IDX_W-1:0]      now_r, now_nxt;
  logic                  last_r, last_nxt;

  logic                  we, re;
  logic [ADDR_W-1:0]     waddr, raddr;
  logic [BLOCK_BITS-1:0] wdata, rdata;

  logic                  accept;
  logic [BLOCK_BITS-1:0] in_blk;
  logic [CNT_W-1:0]      cnt_w, cnt_inc;

  cfbs_ram #(
    .WIDTH(BLOCK_BITS),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign in_blk = in_block_number[BLOCK_BITS-1:0];

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    refilling_nxt = refilling_r;
    seen_nxt      = seen_r;
    expect_nxt    = expect_r;
    k_nxt         = k_r;
    blk_nxt       = blk_r;
    ov_nxt        = 1'b0;
    kind_nxt      = KIND_BUSY;
    rblk_nxt      = '0;
    req_nxt       = 1'b0;
    widx_nxt      = '0;
    wval_nxt      = '0;
    now_nxt       = IDX_W'(count_r);
    last_nxt      = 1'b1;
    we            = 1'b0;
    waddr         = '0;
    wdata         = '0;
    re            = 1'b0;
    raddr         = '0;
    cnt_w         = '0;
    cnt_inc       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          ov_nxt = 1'b1;
          if (refilling_r && in_cmd == CMD_REFILL) begin
            if (!seen_r) begin
              if (in_refill_word > WORD_W'(STACK_DEPTH)) begin
                cnt_w    = DEPTH_C;
                kind_nxt = KIND_CLAMP;
              end else begin
                cnt_w    = in_refill_word[CNT_W-1:0];
                kind_nxt = KIND_ACCEPT;
              end
              expect_nxt = cnt_w;
              count_nxt  = '0;
              seen_nxt   = 1'b1;
              now_nxt    = '0;
              if (cnt_w == '0) begin
                refilling_nxt = 1'b0;
                seen_nxt      = 1'b0;
              end
            end else begin
              if (count_r < DEPTH_C) begin
                we      = 1'b1;
                waddr   = count_r[ADDR_W-1:0];
                wdata   = in_refill_word[BLOCK_BITS-1:0];
                cnt_inc = count_r + ONE_C;
              end else begin
                cnt_inc = count_r;
              end
              count_nxt = cnt_inc;
              kind_nxt  = KIND_ACCEPT;
              now_nxt   = IDX_W'(cnt_inc);
              if (cnt_inc >= expect_r) begin
                refilling_nxt = 1'b0;
                seen_nxt      = 1'b0;
              end
            end
          end else if (refilling_r || in_cmd == CMD_REFILL || in_cmd == CMD_RSVD) begin
            kind_nxt = KIND_BUSY;
          end else if (in_cmd == CMD_ALLOC) begin
            if (count_r == '0) begin
              kind_nxt = KIND_EMPTY;
            end else begin
              ov_nxt    = 1'b0;
              cnt_w     = count_r - ONE_C;
              count_nxt = cnt_w;
              re        = 1'b1;
              raddr     = cnt_w[ADDR_W-1:0];
              state_nxt = S_POP;
            end
          end else begin
            blk_nxt  = in_blk;
            rblk_nxt = WORD_W'(in_blk);
            if (count_r < DEPTH_C) begin
              we        = 1'b1;
              waddr     = count_r[ADDR_W-1:0];
              wdata     = in_blk;
              cnt_inc   = count_r + ONE_C;
              count_nxt = cnt_inc;
              kind_nxt  = KIND_FREED;
              now_nxt   = IDX_W'(cnt_inc);
            end else begin
              // full: count word first, entry reads follow
              kind_nxt  = KIND_SPILL;
              wval_nxt  = WORD_W'(STACK_DEPTH);
              now_nxt   = IDX_W'(STACK_DEPTH);
              last_nxt  = 1'b0;
              re        = 1'b1;
              raddr     = '0;
              k_nxt     = ONE_C;
              state_nxt = S_SPILL;
            end
          end
        end
      end
      S_POP: begin
        ov_nxt    = 1'b1;
        kind_nxt  = KIND_ALLOC;
        rblk_nxt  = WORD_W'(rdata);
        state_nxt = S_IDLE;
        if (count_r == '0 && rdata != '0) begin
          refilling_nxt = 1'b1;
          seen_nxt      = 1'b0;
          expect_nxt    = '0;
          req_nxt       = 1'b1;
        end
      end
      S_SPILL: begin
        ov_nxt   = 1'b1;
        kind_nxt = KIND_SPILL;
        rblk_nxt = WORD_W'(blk_r);
        widx_nxt = IDX_W'(k_r);
        wval_nxt = WORD_W'(rdata);
        now_nxt  = IDX_W'(STACK_DEPTH);
        last_nxt = 1'b0;
        if (k_r < DEPTH_C) begin
          re    = 1'b1;
          raddr = k_r[ADDR_W-1:0];
          k_nxt = k_r + ONE_C;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        we        = 1'b1;
        waddr     = '0;
        wdata     = blk_r;
        count_nxt = ONE_C;
        ov_nxt    = 1'b1;
        kind_nxt  = KIND_FREED;
        rblk_nxt  = WORD_W'(blk_r);
        now_nxt   = IDX_W'(ONE_C);
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      refilling_r <= 1'b0;
      seen_r      <= 1'b0;
      expect_r    <= '0;
      k_r         <= '0;
      ov_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      refilling_r <= refilling_nxt;
      seen_r      <= seen_nxt;
      expect_r    <= expect_nxt;
      k_r         <= k_nxt;
      ov_r        <= ov_nxt;
      blk_r       <= blk_nxt;
      kind_r      <= kind_nxt;
      rblk_r      <= rblk_nxt;
      req_r       <= req_nxt;
      widx_r      <= widx_nxt;
      wval_r      <= wval_nxt;
      now_r       <= now_nxt;
      last_r      <= last_nxt;
    end
  end

  assign out_valid          = ov_r;
  assign out_kind           = kind_r;
  assign out_result_block   = rblk_r;
  assign out_refill_request = req_r;
  assign out_word_index     = widx_r;
  assign out_word_value     = wval_r;
  assign out_entries_now    = now_r;
  assign out_last           = last_r;

`ifndef ASSERT_OFF
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_kind != KIND_SPILL)))
    else $error("last flag does not match result kind");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("entry count above stack depth");

  a_req_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_refill_request) |->
      (out_kind == KIND_ALLOC && out_entries_now == '0 && refilling_r))
    else $error("refill request without emptied stack");

  a_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !refilling_r && in_cmd == CMD_ALLOC && count_r != '0) |=>
      (busy && !out_valid))
    else $error("pop did not wait for stack read");
`endif

endmodule

// ===== hdl/cfbs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cfbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== tb/tb_chained_free_block_stack.sv =====
`timescale 1ns / 1ps
// Self-checking bench for chained_free_block_stack: directed and random command streams.
// Depends on cfbs_pkg and the block's RTL; carries its own model of the stack.

module tb_chained_free_block_stack;
  import cfbs_pkg::*;

  typedef struct {
    kind_t              kind;
    logic [WORD_W-1:0]  block;
    logic               refill_req;
    logic [IDX_W-1:0]   index;
    logic [WORD_W-1:0]  value;
    logic [IDX_W-1:0]   entries;
    logic               last;
  } stack_result_t;

  class stack_scoreboard;
    logic [WORD_W-1:0] blocks [STACK_DEPTH];
    int unsigned       depth_now;
    int unsigned       refill_target;
    int unsigned       refill_pos;
    bit                refilling;
    stack_result_t     pending[$];
    int                errors;
    int                checked;
    int                commands;
    int                kind_seen [8];

    function logic [WORD_W-1:0] keep_bits(logic [WORD_W-1:0] x);
      return x & 32'((64'd1 << BLOCK_BITS) - 1);
    endfunction

    function void push(kind_t k, logic [WORD_W-1:0] blk, bit req, int unsigned idx,
                       logic [WORD_W-1:0] val, bit fin);
      stack_result_t r;
      r.kind       = k;
      r.block      = blk;
      r.refill_req = req;
      r.index      = idx[IDX_W-1:0];
      r.value      = val;
      r.entries    = depth_now[IDX_W-1:0];
      r.last       = fin;
      pending.push_back(r);
    endfunction

    // Updates the stack copy for one accepted transfer and queues its results.
    function void note_command(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] blk_in,
                               logic [WORD_W-1:0] word);
      logic [WORD_W-1:0] blk;
      logic [WORD_W-1:0] got;
      kind_t             k;
      bit                req;
      blk = keep_bits(blk_in);
      commands++;
      if (refilling && cmd == CMD_REFILL) begin
        if (refill_pos == 0) begin
          k = KIND_ACCEPT;
          if (word > STACK_DEPTH) begin
            refill_target = STACK_DEPTH;
            k = KIND_CLAMP;
          end else begin
            refill_target = word;
          end
          refill_pos = 1;
          depth_now  = 0;
          if (refill_target == 0) begin
            refilling  = 0;
            refill_pos = 0;
          end
          push(k, '0, 0, 0, '0, 1);
          return;
        end
        if (depth_now < STACK_DEPTH) begin
          blocks[depth_now] = keep_bits(word);
          depth_now++;
        end
        refill_pos++;
        if (depth_now >= refill_target) begin
          refilling  = 0;
          refill_pos = 0;
        end
        push(KIND_ACCEPT, '0, 0, 0, '0, 1);
        return;
      end
      if (refilling || cmd == CMD_REFILL || cmd == CMD_RSVD) begin
        push(KIND_BUSY, '0, 0, 0, '0, 1);
        return;
      end
      if (cmd == CMD_ALLOC) begin
        if (depth_now == 0 || depth_now > STACK_DEPTH) begin
          push(KIND_EMPTY, '0, 0, 0, '0, 1);
          return;
        end
        depth_now--;
        got = blocks[depth_now];
        req = 0;
        if (depth_now == 0 && got != 0) begin
          refilling     = 1;
          refill_pos    = 0;
          refill_target = 0;
          req           = 1;
        end
        push(KIND_ALLOC, got, req, 0, '0, 1);
        return;
      end
      if (depth_now >= STACK_DEPTH) begin
        push(KIND_SPILL, blk, 0, 0, STACK_DEPTH, 0);
        for (int i = 0; i < STACK_DEPTH; i++)
          push(KIND_SPILL, blk, 0, i + 1, blocks[i], 0);
        depth_now = 0;
      end
      blocks[depth_now] = blk;
      depth_now++;
      push(KIND_FREED, blk, 0, 0, '0, 1);
    endfunction

    task report(string what);
      errors++;
      if (errors <= 25)
        $display("mismatch at %0t ns: %s", $time, what);
    endtask

    task check_result(stack_result_t got);
      stack_result_t want;
      if (pending.size() == 0) begin
        report($sformatf("result of kind %0d with no transfer outstanding", got.kind));
        return;
      end
      want = pending.pop_front();
      checked++;
      kind_seen[got.kind]++;
      if (got.kind !== want.kind)
        report($sformatf("result %0d kind %0d, want %0d", checked, got.kind, want.kind));
      if (got.block !== want.block)
        report($sformatf("result %0d block %h, want %h", checked, got.block, want.block));
      if (got.refill_req !== want.refill_req)
        report($sformatf("result %0d refill request %b, want %b", checked, got.refill_req,
                         want.refill_req));
      if (got.index !== want.index)
        report($sformatf("result %0d word index %0d, want %0d", checked, got.index,
                         want.index));
      if (got.value !== want.value)
        report($sformatf("result %0d word value %h, want %h", checked, got.value, want.value));
      if (got.entries !== want.entries)
        report($sformatf("result %0d entries %0d, want %0d", checked, got.entries,
                         want.entries));
      if (got.last !== want.last)
        report($sformatf("result %0d last %b, want %b", checked, got.last, want.last));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [CMD_W-1:0]  in_cmd = CMD_ALLOC;
  logic [WORD_W-1:0] in_block_number = '0;
  logic [WORD_W-1:0] in_refill_word = '0;
  logic              out_valid;
  logic [2:0]        out_kind;
  logic [WORD_W-1:0] out_result_block;
  logic              out_refill_request;
  logic [IDX_W-1:0]  out_word_index;
  logic [WORD_W-1:0] out_word_value;
  logic [IDX_W-1:0]  out_entries_now;
  logic              out_last;

  stack_scoreboard book = new();
  int              burst_left = 0;

  chained_free_block_stack dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_cmd             (in_cmd),
    .in_block_number    (in_block_number),
    .in_refill_word     (in_refill_word),
    .out_valid          (out_valid),
    .out_kind           (out_kind),
    .out_result_block   (out_result_block),
    .out_refill_request (out_refill_request),
    .out_word_index     (out_word_index),
    .out_word_value     (out_word_value),
    .out_entries_now    (out_entries_now),
    .out_last           (out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Results are checked before a transfer at the same edge is noted.
  always @(posedge clk) begin
    stack_result_t seen;
    if (rst_n) begin
      if (out_valid) begin
        seen.kind       = kind_t'(out_kind);
        seen.block      = out_result_block;
        seen.refill_req = out_refill_request;
        seen.index      = out_word_index;
        seen.value      = out_word_value;
        seen.entries    = out_entries_now;
        seen.last       = out_last;
        book.check_result(seen);
      end
      if (start && !busy)
        book.note_command(in_cmd, in_block_number, in_refill_word);
    end
  end

  function automatic int next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0)
      burst_left = $urandom_range(10, 40);
    return $urandom_range(0, 12);
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8)
      return '0;
    if (r < 12)
      return '1;
    return $urandom();
  endfunction

  function automatic logic [WORD_W-1:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10)
      return 0;
    if (r < 70)
      return $urandom_range(1, 8);
    if (r < 90)
      return $urandom_range(9, STACK_DEPTH);
    if (r < 96)
      return $urandom_range(STACK_DEPTH + 1, 255);
    return '1;
  endfunction

  // Entered and left at a falling edge; start stays high after a transfer.
  task automatic send(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] blk,
                      input logic [WORD_W-1:0] word);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start           <= 1'b1;
    in_cmd          <= cmd;
    in_block_number <= blk;
    in_refill_word  <= word;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (book.pending.size() > 0)
      @(negedge clk);
  endtask

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [CMD_W-1:0]  cmd;
    logic [WORD_W-1:0] blk;
    logic [WORD_W-1:0] word;
    int                useful;
    int unsigned       r;
    bit                filling;

    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    @(negedge clk);

    send(CMD_ALLOC,  32'h0000_0000, 32'h0000_0000);   // pop on empty stack
    send(CMD_FREE,   32'h0000_0000, 32'hFFFF_FFFF);
    send(CMD_FREE,   32'hFFFF_FFFF, 32'h0000_0000);
    send(CMD_ALLOC,  32'h0000_0000, 32'h0000_0000);
    send(CMD_ALLOC,  32'hFFFF_FFFF, 32'h0000_0000);   // end of chain, no refill
    send(CMD_REFILL, 32'h0000_0000, 32'h0000_0003);   // refill word while idle
    send(CMD_RSVD,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(CMD_FREE,   32'h0000_0009, 32'h0000_0000);
    send(CMD_ALLOC,  32'h0000_0000, 32'h0000_0000);   // asks for a refill
    send(CMD_ALLOC,  32'h0000_0000, 32'h0000_0000);
    send(CMD_FREE,   32'h1234_5678, 32'h0000_0000);
    send(CMD_RSVD,   32'h0000_0000, 32'h0000_0000);
    send(CMD_REFILL, 32'h0000_0000, 32'h0000_0000);   // empty refill
    send(CMD_FREE,   32'hA5A5_5A5A, 32'h0000_0000);
    send(CMD_ALLOC,  32'h0000_0000, 32'h0000_0000);
    send(CMD_REFILL, 32'h0000_0000, 32'h0000_0002);
    send(CMD_REFILL, 32'h0000_0000, 32'hFFFF_FFFF);
    send(CMD_REFILL, 32'h0000_0000, 32'h0000_0000);
    send(CMD_ALLOC,  32'h0000_0000, 32'h0000_0000);
    send(CMD_ALLOC,  32'h0000_0000, 32'h0000_0000);
    send(CMD_REFILL, 32'h0000_0000, 32'd100);         // count above depth
    drain();

    // random part picks up the clamped refill where the directed part left it
    useful  = 0;
    filling = 1;
    while (useful < 280) begin
      blk  = pick_word();
      word = pick_word();
      r    = $urandom_range(0, 99);
      if (book.refilling) begin
        if (r < 8) begin
          case ($urandom_range(0, 2))
            0:       cmd = CMD_ALLOC;
            1:       cmd = CMD_FREE;
            default: cmd = CMD_RSVD;
          endcase
        end else begin
          cmd = CMD_REFILL;
          if (book.refill_pos == 0)
            word = pick_count();
        end
      end else begin
        if (book.depth_now == 0)
          filling = ($urandom_range(0, 3) != 0);
        else if (book.depth_now == STACK_DEPTH && $urandom_range(0, 2) == 0)
          filling = 0;
        if (r < 4)
          cmd = CMD_REFILL;
        else if (r < 7)
          cmd = CMD_RSVD;
        else if (filling ? (r < 80) : (r < 27))
          cmd = CMD_FREE;
        else
          cmd = CMD_ALLOC;
      end
      if (book.refilling ? (cmd == CMD_REFILL) : (cmd == CMD_ALLOC || cmd == CMD_FREE))
        useful++;
      send(cmd, blk, word);
      if (useful % 64 == 63)
        drain();
    end

    drain();
    repeat (2 * STACK_DEPTH + 8) @(negedge clk);

    $display("Covered %0d transfers: %0d allocations, %0d empty pops, %0d frees, %0d spill words",
             book.commands, book.kind_seen[KIND_ALLOC], book.kind_seen[KIND_EMPTY],
             book.kind_seen[KIND_FREED], book.kind_seen[KIND_SPILL]);
    $display("  %0d refill words, %0d clamped counts, %0d busy answers, %0d results checked",
             book.kind_seen[KIND_ACCEPT], book.kind_seen[KIND_CLAMP],
             book.kind_seen[KIND_BUSY], book.checked);
    if (book.errors == 0 && book.pending.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
